[design/avne_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the ADC LSB entropy core.
// Used by avne_extractor and adc_lsb_von_neumann_entropy_core; no dependencies.
package avne_pkg;

  // Default sizes of the entropy path.
  localparam int POOL_BITS_DEF   = 64;
  localparam int WORD_BITS_DEF   = 32;
  localparam int ENTROPY_BIT_DEF = 6;

  // Fixed port widths.
  localparam int SAMPLE_W = 16;
  localparam int CH_W     = 2;
  localparam int RWORD_W  = 32;

  // Channel codes of the conversion sequence.
  localparam logic [CH_W-1:0] CH_REF   = 2'd0;
  localparam logic [CH_W-1:0] CH_3     = 2'd1;
  localparam logic [CH_W-1:0] CH_4     = 2'd2;
  localparam logic [CH_W-1:0] CH_OTHER = 2'd3;

  // Status of the extractor as seen by the sequencer.
  typedef struct packed {
    logic busy;        // pool walk in progress
    logic word_valid;  // last walk completed a word
  } avne_ext_stat_t;

endpackage

[design/avne_extractor.sv]
`timescale 1ns / 1ps
// Entropy pool and Von Neumann extractor, walking one bit pair per cycle.
// Depends on avne_pkg.
module avne_extractor import avne_pkg::*; #(
  parameter int POOL_BITS = POOL_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  logic                 bit_i,
  output logic                 last_o,
  output avne_ext_stat_t       stat_o,
  output logic [WORD_BITS-1:0] word_o
);

  localparam int PAIRS   = POOL_BITS / 2;
  localparam int FILL_W  = $clog2(POOL_BITS);
  localparam int PCNT_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int WFILL_W = $clog2(WORD_BITS + 1);

  logic [POOL_BITS-1:0] pool_r, pool_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [PCNT_W-1:0]    pcnt_r, pcnt_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [WFILL_W-1:0]   wfill_r, wfill_nxt;
  logic                 busy_r, busy_nxt;
  logic                 wvalid_r, wvalid_nxt;
  logic                 word_done;

  // The next push fills the pool and starts a walk.
  assign last_o = (fill_r == FILL_W'(POOL_BITS - 1));

  // Pool fill on a push, or one pair of the walk per cycle, newest pair first.
  always_comb begin
    pool_nxt   = pool_r;
    fill_nxt   = fill_r;
    pcnt_nxt   = pcnt_r;
    acc_nxt    = acc_r;
    wfill_nxt  = wfill_r;
    busy_nxt   = busy_r;
    wvalid_nxt = wvalid_r;
    word_done  = 1'b0;
    if (busy_r) begin
      pool_nxt = pool_r >> 2;
      pcnt_nxt = pcnt_r + PCNT_W'(1);
      if (pool_r[0] != pool_r[1]) begin
        acc_nxt   = (acc_r << 1) | WORD_BITS'(pool_r[1]);
        wfill_nxt = wfill_r + WFILL_W'(1);
      end
      word_done = (wfill_nxt == WFILL_W'(WORD_BITS));
      if (word_done) begin
        wfill_nxt  = '0;
        wvalid_nxt = 1'b1;
      end
      // The walk ends on a full word or after the last pair; the rest is dropped.
      if (word_done || (pcnt_r == PCNT_W'(PAIRS - 1))) begin
        busy_nxt = 1'b0;
        pool_nxt = '0;
      end
    end else if (push_i) begin
      pool_nxt   = (pool_r << 1) | POOL_BITS'(bit_i);
      wvalid_nxt = 1'b0;
      if (last_o) begin
        fill_nxt = '0;
        busy_nxt = 1'b1;
        pcnt_nxt = '0;
      end else begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
  end

  // State registers; the pool and the word start cleared.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r   <= '0;
      fill_r   <= '0;
      pcnt_r   <= '0;
      acc_r    <= '0;
      wfill_r  <= '0;
      busy_r   <= 1'b0;
      wvalid_r <= 1'b0;
    end else begin
      pool_r   <= pool_nxt;
      fill_r   <= fill_nxt;
      pcnt_r   <= pcnt_nxt;
      acc_r    <= acc_nxt;
      wfill_r  <= wfill_nxt;
      busy_r   <= busy_nxt;
      wvalid_r <= wvalid_nxt;
    end
  end

  assign stat_o.busy       = busy_r;
  assign stat_o.word_valid = wvalid_r;
  assign word_o            = acc_r;

endmodule

[design/adc_lsb_von_neumann_entropy_core.sv]
`timescale 1ns / 1ps
// ADC sample sequencer with LSB entropy harvesting; top level.
// A sample that does not fill the pool is presented in the cycle after its transfer.
// A reference sample that fills the pool starts a walk of up to POOL_BITS/2 pairs, one per cycle;
// its result is presented once the walk ends, early if a word completes, and the output is free.
// Throughput: one sample per cycle while the output is not stalled; no sample is taken during a walk.
// Synchronous active-low reset: channel 4 is current, pool and word are empty, no result held.
module adc_lsb_von_neumann_entropy_core import avne_pkg::*; #(
  parameter int POOL_BITS   = POOL_BITS_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF,
  parameter int ENTROPY_BIT = ENTROPY_BIT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_raw_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CH_W-1:0]     out_sampled_channel,
  output logic [SAMPLE_W-1:0] out_sample_value,
  output logic [CH_W-1:0]     out_next_channel,
  output logic [RWORD_W-1:0]  out_random_word,
  output logic                out_word_valid
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic [CH_W-1:0]      ch_r, ch_nxt;
  logic [CH_W-1:0]      ch_follow;
  logic [SAMPLE_W-1:0]  smp_r, smp_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]      sch_r, sch_nxt;
  logic [SAMPLE_W-1:0]  sval_r, sval_nxt;
  logic [CH_W-1:0]      nch_r, nch_nxt;
  logic [RWORD_W-1:0]   rword_r, rword_nxt;
  logic                 wval_r, wval_nxt;
  logic                 out_free;
  logic                 in_xfer;
  logic                 push;
  logic                 ext_last;
  avne_ext_stat_t       ext_stat;
  logic [WORD_BITS-1:0] ext_word;

  // The output slot is free when empty or when its result transfers now.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_xfer  = in_valid && !in_stall;
  assign push     = in_xfer && (ch_r == CH_REF);

  // Round robin: reference, channel 3, channel 4; an unknown channel returns to reference.
  always_comb begin
    case (ch_r)
      CH_REF:  ch_follow = CH_3;
      CH_3:    ch_follow = CH_4;
      CH_4:    ch_follow = CH_REF;
      default: ch_follow = CH_REF;
    endcase
  end

  avne_extractor #(
    .POOL_BITS (POOL_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_ext (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .bit_i  (in_raw_sample[ENTROPY_BIT]),
    .last_o (ext_last),
    .stat_o (ext_stat),
    .word_o (ext_word)
  );

  // Sequencer and output register.
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    smp_nxt       = smp_r;
    out_valid_nxt = out_valid_r && out_stall;
    sch_nxt       = sch_r;
    sval_nxt      = sval_r;
    nch_nxt       = nch_r;
    rword_nxt     = rword_r;
    wval_nxt      = wval_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          ch_nxt = ch_follow;
          if (push && ext_last) begin
            smp_nxt   = in_raw_sample;
            state_nxt = ST_WALK;
          end else begin
            out_valid_nxt = 1'b1;
            sch_nxt       = ch_r;
            sval_nxt      = (ch_r == CH_OTHER) ? '0 : in_raw_sample;
            nch_nxt       = ch_follow;
            rword_nxt     = RWORD_W'(ext_word);
            wval_nxt      = 1'b0;
          end
        end
      end
      ST_WALK: begin
        if (!ext_stat.busy && out_free) begin
          out_valid_nxt = 1'b1;
          sch_nxt       = CH_REF;
          sval_nxt      = smp_r;
          nch_nxt       = CH_3;
          rword_nxt     = RWORD_W'(ext_word);
          wval_nxt      = ext_stat.word_valid;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state is reset; payload registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= CH_4;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r   <= smp_nxt;
    sch_r   <= sch_nxt;
    sval_r  <= sval_nxt;
    nch_r   <= nch_nxt;
    rword_r <= rword_nxt;
    wval_r  <= wval_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_sampled_channel = sch_r;
  assign out_sample_value    = sval_r;
  assign out_next_channel    = nch_r;
  assign out_random_word     = rword_r;
  assign out_word_valid      = wval_r;

  // The extractor only walks while the sequencer waits for it.
  a_busy_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ext_stat.busy |-> (state_r == ST_WALK))
    else $error("extractor busy outside of a walk");

  // A sample that fills the pool starts a walk in the next cycle.
  a_walk_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (push && ext_last) |=> ext_stat.busy)
    else $error("full pool did not start a walk");

  // A completed word can only come with a reference sample.
  a_word_on_ref: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && wval_r) |-> (sch_r == CH_REF))
    else $error("word completed on a non-reference sample");

  // The sequence never reaches the unknown channel code.
  a_no_other: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r != CH_OTHER)
    else $error("channel register holds the unknown code");

endmodule
